// File: src/silc_pkg.sv
// Shared constants and types for the serial image loader with CRC-32 check.
// No dependencies; imported by every module of the block.
package silc_pkg;

   localparam int OFFSET_WIDTH = 16;
   localparam int LIMIT_WIDTH  = 17;
   localparam int COUNT_WIDTH  = 17;

   localparam logic [31:0] START_WORD = 32'h6D63_656E;
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 17'h1_0000;

   typedef enum logic [2:0] {
      EV_GO    = 3'd0,
      EV_BIG   = 3'd1,
      EV_WRITE = 3'd2,
      EV_FAIL  = 3'd3,
      EV_OK    = 3'd4
   } event_type;

endpackage

// File: src/serial_image_loader_crc32_top.sv
// Top level of the serial image loader: start-word hunt, length and check
// fields, memory write events and CRC-32 compare. Depends on silc_pkg and
// silc_crc_byte.
// An accepted beat waits in the input register until the result register frees;
// it is then processed, and any result it yields is registered onto rsp_.
// Throughput: one byte per cycle while rsp_ is not stalled; the one-byte CRC update sets the path.
// Reset (synchronous): hunting, all fields cleared, CRC all ones, limit 65536.
module serial_image_loader_crc32_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_event_res,
   output logic [silc_pkg::OFFSET_WIDTH-1:0]  rsp_write_offset,
   output logic [7:0]                         rsp_write_data,
   output logic [31:0]                        rsp_computed_check,
   input  logic                               csr_we,
   input  logic [silc_pkg::LIMIT_WIDTH-1:0]   csr_wdata
);
   import silc_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT, PH_LEN, PH_DATA, PH_CHECK, PH_IDLE
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [31:0]              start_shift_ff, start_shift_in;
   logic [1:0]               field_cnt_ff, field_cnt_in;
   logic [31:0]              image_length_ff, image_length_in;
   logic [COUNT_WIDTH-1:0]   byte_offset_ff, byte_offset_in;
   logic [31:0]              running_crc_ff, running_crc_in;
   logic [31:0]              received_check_ff, received_check_in;
   logic [LIMIT_WIDTH-1:0]   max_size_ff;

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   event_type                rsp_event_ff, rsp_event_in;
   logic [OFFSET_WIDTH-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [7:0]               rsp_data_ff, rsp_data_in;
   logic [31:0]              rsp_check_ff, rsp_check_in;

   logic                     advance;
   logic                     fire;
   logic                     req_fire;
   logic [31:0]              crc_upd;
   logic [31:0]              byte_placed;
   logic [31:0]              length_full;
   logic [31:0]              check_full;
   logic [31:0]              crc_final;
   logic [COUNT_WIDTH-1:0]   offset_inc;

   silc_crc_byte u_crc (
      .crc_cur   (running_crc_ff),
      .data_byte (in_byte_ff),
      .crc_next  (crc_upd)
   );

   // The result register frees when empty or being taken; the input register
   // then moves its beat on, so one more beat can wait behind a stalled result.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign byte_placed = {24'd0, in_byte_ff} << {field_cnt_ff, 3'b000};
   assign length_full = image_length_ff | byte_placed;
   assign check_full  = received_check_ff | byte_placed;
   assign crc_final   = ~running_crc_ff;
   assign offset_inc  = byte_offset_ff + COUNT_WIDTH'(1);

   always_comb begin
      phase_in          = phase_ff;
      start_shift_in    = start_shift_ff;
      field_cnt_in      = field_cnt_ff;
      image_length_in   = image_length_ff;
      byte_offset_in    = byte_offset_ff;
      running_crc_in    = running_crc_ff;
      received_check_in = received_check_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_event_in      = rsp_event_ff;
      rsp_offset_in     = rsp_offset_ff;
      rsp_data_in       = rsp_data_ff;
      rsp_check_in      = rsp_check_ff;
      in_valid_in       = in_valid_ff && !advance;

      if (req_fire) begin
         in_valid_in = 1'b1;
      end

      if (fire) begin
         case (phase_ff)
            PH_HUNT: begin
               start_shift_in = {start_shift_ff[23:0], in_byte_ff};
               if ({start_shift_ff[23:0], in_byte_ff} == START_WORD) begin
                  phase_in        = PH_LEN;
                  field_cnt_in    = 2'd0;
                  image_length_in = 32'd0;
                  rsp_valid_in    = 1'b1;
                  rsp_event_in    = EV_GO;
                  rsp_offset_in   = '0;
                  rsp_data_in     = 8'd0;
                  rsp_check_in    = 32'd0;
               end
            end
            PH_LEN: begin
               image_length_in = length_full;
               if (field_cnt_ff != 2'd3) begin
                  field_cnt_in = field_cnt_ff + 2'd1;
               end else begin
                  field_cnt_in = 2'd0;
                  if (length_full >= {{(32-LIMIT_WIDTH){1'b0}}, max_size_ff}) begin
                     phase_in       = PH_HUNT;
                     start_shift_in = 32'd0;
                     rsp_valid_in   = 1'b1;
                     rsp_event_in   = EV_BIG;
                     rsp_offset_in  = '0;
                     rsp_data_in    = 8'd0;
                     rsp_check_in   = 32'd0;
                  end else begin
                     byte_offset_in    = '0;
                     running_crc_in    = CRC_INIT;
                     received_check_in = 32'd0;
                     phase_in = (length_full == 32'd0) ? PH_CHECK : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               running_crc_in = crc_upd;
               byte_offset_in = offset_inc;
               if ({{(32-COUNT_WIDTH){1'b0}}, offset_inc} >= image_length_ff) begin
                  phase_in          = PH_CHECK;
                  field_cnt_in      = 2'd0;
                  received_check_in = 32'd0;
               end
               rsp_valid_in  = 1'b1;
               rsp_event_in  = EV_WRITE;
               rsp_offset_in = OFFSET_WIDTH'(byte_offset_ff[15:0]);
               rsp_data_in   = in_byte_ff;
               rsp_check_in  = 32'd0;
            end
            PH_CHECK: begin
               received_check_in = check_full;
               if (field_cnt_ff != 2'd3) begin
                  field_cnt_in = field_cnt_ff + 2'd1;
               end else begin
                  field_cnt_in  = 2'd0;
                  rsp_valid_in  = 1'b1;
                  rsp_offset_in = '0;
                  rsp_data_in   = 8'd0;
                  rsp_check_in  = crc_final;
                  if (crc_final != check_full) begin
                     phase_in       = PH_HUNT;
                     start_shift_in = 32'd0;
                     rsp_event_in   = EV_FAIL;
                  end else begin
                     phase_in     = PH_IDLE;
                     rsp_event_in = EV_OK;
                  end
               end
            end
            default: begin
               // After success every beat is dropped without a result.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         start_shift_ff    <= 32'd0;
         field_cnt_ff      <= 2'd0;
         image_length_ff   <= 32'd0;
         byte_offset_ff    <= '0;
         running_crc_ff    <= CRC_INIT;
         received_check_ff <= 32'd0;
         max_size_ff       <= LIMIT_RESET;
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         start_shift_ff    <= start_shift_in;
         field_cnt_ff      <= field_cnt_in;
         image_length_ff   <= image_length_in;
         byte_offset_ff    <= byte_offset_in;
         running_crc_ff    <= running_crc_in;
         received_check_ff <= received_check_in;
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_we) begin
            max_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_rx_byte;
      end
      rsp_event_ff  <= rsp_event_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_check_ff  <= rsp_check_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = rsp_event_ff;
   assign rsp_write_offset   = rsp_offset_ff;
   assign rsp_write_data     = rsp_data_ff;
   assign rsp_computed_check = rsp_check_ff;

`ifndef ASSERT_OFF
   a_idle_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |=> phase_ff == PH_IDLE)
      else $error("loader left idle after success");

   a_count_in_field: assert property (@(posedge clock) disable iff (reset)
      field_cnt_ff != 2'd0 |-> (phase_ff == PH_LEN || phase_ff == PH_CHECK))
      else $error("field byte count set outside length or check phase");

   a_stall_holds_beat: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("buffered beat lost while the result stage stalled");

   a_write_has_no_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff == EV_WRITE |-> rsp_check_ff == 32'd0)
      else $error("memory write result carries a check value");
`endif

endmodule

// File: src/silc_crc_byte.sv
// Reflected CRC-32 update for one byte, eight bit steps unrolled.
// Depends on silc_pkg for the polynomial.
module silc_crc_byte (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);
   import silc_pkg::*;

   always_comb begin
      logic [31:0] acc;
      acc = crc_cur ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         acc = {1'b0, acc[31:1]} ^ (CRC_POLY & {32{acc[0]}});
      end
      crc_next = acc;
   end

endmodule
